// ===== hdl/rpy_pkg.sv =====
package rpy_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int XW = 34;
    localparam logic signed [XW-1:0] GAIN_INIT = 34'sh026DD3B6A;
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    typedef struct packed {
        logic        opcode;
        logic [15:0] roll_angle;
        logic [15:0] pitch_angle;
        logic [15:0] yaw_angle;
        logic [15:0] bone_length;
    } rpy_in_t;

    typedef struct packed {
        logic [15:0] m00;
        logic [15:0] m01;
        logic [15:0] m02;
        logic [15:0] m10;
        logic [15:0] m11;
        logic [15:0] m12;
        logic [15:0] m20;
        logic [15:0] m21;
        logic [15:0] m22;
        logic [15:0] trans_x;
    } rpy_out_t;

    // one angle's rotator state
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [32:0]   z;
        logic                 flip;
    } rpy_rot_t;

    // word moving down the chain
    typedef struct packed {
        logic     valid;
        rpy_rot_t r;
        rpy_rot_t p;
        rpy_rot_t w;
        logic        opcode;
        logic [15:0] bone_length;
    } rpy_link_t;

    function automatic logic signed [32:0] atan_val(input int i);
        logic [31:0] t;
        unique case (i)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; default: t = 32'h00000051;
        endcase
        return $signed({1'b0, t});
    endfunction

    function automatic logic signed [15:0] sat_q14(input logic signed [47:0] v);
        if (v > 48'sd16384) return Q14_ONE;
        if (v < -48'sd16384) return -Q14_ONE;
        return v[15:0];
    endfunction

endpackage

// ===== hdl/rpy_cell.sv =====
module rpy_cell
    import rpy_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [4:0]       shift,
    input  logic signed [32:0] atan,
    input  rpy_link_t        link_in,
    output rpy_link_t        link_out
);

    rpy_link_t link_reg, link_next;

    function automatic rpy_rot_t rot_step(input rpy_rot_t a, input logic [4:0] s,
                                          input logic signed [32:0] t);
        rpy_rot_t o;
        logic signed [XW-1:0] ys, xs;
        o  = a;
        ys = a.y >>> s;
        xs = a.x >>> s;
        if (!a.z[32]) begin
            o.x = a.x - ys;
            o.y = a.y + xs;
            o.z = a.z - t;
        end else begin
            o.x = a.x + ys;
            o.y = a.y - xs;
            o.z = a.z + t;
        end
        return o;
    endfunction

    always_comb begin
        link_next   = link_in;
        link_next.r = rot_step(link_in.r, shift, atan);
        link_next.p = rot_step(link_in.p, shift, atan);
        link_next.w = rot_step(link_in.w, shift, atan);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg.valid <= 1'b0;
        end else if (en) begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

// ===== hdl/rpy_matrix.sv =====
module rpy_matrix
    import rpy_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  rpy_link_t link_in,
    output logic      valid_out,
    output rpy_out_t  data_out
);

    function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v,
                                                  input logic f);
        logic signed [XW-1:0] t;
        logic signed [15:0] s;
        t = (v + XW'(32768)) >>> 16;
        s = sat_q14(48'(t));
        return f ? -s : s;
    endfunction

    // stage a: sines and cosines
    logic v1_reg, v2_reg, v3_reg;
    logic signed [15:0] sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    logic op1_reg; logic [15:0] bl1_reg;
    // stage b: pairwise products (Q.28)
    logic signed [31:0] cysp_reg, sysp_reg, sycr_reg, sysr_reg, cycr_reg, cysr_reg;
    logic signed [31:0] cycp_reg, sycp_reg, cpsr_reg, cpcr_reg;
    logic signed [15:0] sr2_reg, cr2_reg, nsp_reg;
    logic op2_reg; logic [15:0] bl2_reg;
    // stage c: three factor terms (Q.42)
    logic signed [47:0] t01_reg, t02_reg, t11_reg, t12_reg;
    logic signed [47:0] u01_reg, u02_reg, u11_reg, u12_reg;
    logic signed [31:0] cycp3_reg, sycp3_reg, cpsr3_reg, cpcr3_reg;
    logic signed [15:0] nsp3_reg;
    logic op3_reg; logic [15:0] bl3_reg;
    rpy_out_t out_reg, out_next;

    function automatic logic signed [15:0] rnd2(input logic signed [31:0] p);
        return sat_q14(48'((33'(p) + 33'sd8192) >>> 14));
    endfunction
    function automatic logic signed [15:0] rnd3(input logic signed [48:0] p);
        return sat_q14(48'((p + 49'sd134217728) >>> 28));
    endfunction

    always_comb begin
        out_next.m00 = rnd2(cycp3_reg);
        out_next.m10 = rnd2(sycp3_reg);
        out_next.m21 = rnd2(cpsr3_reg);
        out_next.m22 = rnd2(cpcr3_reg);
        out_next.m20 = nsp3_reg;
        out_next.m01 = rnd3(49'(t01_reg) - 49'(u01_reg));
        out_next.m02 = rnd3(49'(t02_reg) + 49'(u02_reg));
        out_next.m11 = rnd3(49'(t11_reg) + 49'(u11_reg));
        out_next.m12 = rnd3(49'(t12_reg) - 49'(u12_reg));
        out_next.trans_x = op3_reg ? bl3_reg : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; valid_out <= 1'b0;
        end else if (en) begin
            v1_reg <= link_in.valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
            valid_out <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg <= to_q14(link_in.r.y, link_in.r.flip);
            cr_reg <= to_q14(link_in.r.x, link_in.r.flip);
            sp_reg <= to_q14(link_in.p.y, link_in.p.flip);
            cp_reg <= to_q14(link_in.p.x, link_in.p.flip);
            sy_reg <= to_q14(link_in.w.y, link_in.w.flip);
            cy_reg <= to_q14(link_in.w.x, link_in.w.flip);
            op1_reg <= link_in.opcode; bl1_reg <= link_in.bone_length;

            cysp_reg <= cy_reg * sp_reg; sysp_reg <= sy_reg * sp_reg;
            sycr_reg <= sy_reg * cr_reg; sysr_reg <= sy_reg * sr_reg;
            cycr_reg <= cy_reg * cr_reg; cysr_reg <= cy_reg * sr_reg;
            cycp_reg <= cy_reg * cp_reg; sycp_reg <= sy_reg * cp_reg;
            cpsr_reg <= cp_reg * sr_reg; cpcr_reg <= cp_reg * cr_reg;
            sr2_reg <= sr_reg; cr2_reg <= cr_reg;
            nsp_reg <= sat_q14(-48'(sp_reg));
            op2_reg <= op1_reg; bl2_reg <= bl1_reg;

            t01_reg <= 48'(cysp_reg) * 48'(sr2_reg);
            t02_reg <= 48'(cysp_reg) * 48'(cr2_reg);
            t11_reg <= 48'(sysp_reg) * 48'(sr2_reg);
            t12_reg <= 48'(sysp_reg) * 48'(cr2_reg);
            u01_reg <= 48'(sycr_reg) <<< 14; u02_reg <= 48'(sysr_reg) <<< 14;
            u11_reg <= 48'(cycr_reg) <<< 14; u12_reg <= 48'(cysr_reg) <<< 14;
            cycp3_reg <= cycp_reg; sycp3_reg <= sycp_reg;
            cpsr3_reg <= cpsr_reg; cpcr3_reg <= cpcr_reg;
            nsp3_reg <= nsp_reg; op3_reg <= op2_reg; bl3_reg <= bl2_reg;

            data_out <= out_next;
        end
    end

endmodule

// ===== hdl/rpy_to_homogeneous_transform.sv =====
// roll/pitch/yaw to rotation matrix, z-y-x order
// input channel s_: one word holds opcode, three binary angles and bone length
// result channel m_: one word holds the nine q1.14 rotation entries and x translation
// each angle runs through its own lane of a cordic chain, one cell per iteration
// throughput: one word per cycle, a new word may enter every cycle that s_ready is high
// CORDIC_STAGES + 4 register stages: one per cordic cell, then four in rpy_matrix
// the chain and product pipeline form one stall domain: when the receiver holds
// m_ready low with a result waiting, the whole pipeline freezes
// s_ready = m_ready or the result register is empty
// reset clears all valid flags; payload registers are not reset
module rpy_to_homogeneous_transform
    import rpy_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rpy_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rpy_out_t m_data
);

    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    // fold an angle into [-pi/2, pi/2) and build the start state
    function automatic rpy_rot_t seed(input logic [15:0] a);
        rpy_rot_t o;
        logic [31:0] ph;
        ph     = {a, 16'd0};
        o.flip = ph[31] ^ ph[30];
        if (o.flip) ph = ph + 32'h80000000;
        o.z = $signed({ph[31], ph});
        o.x = GAIN_INIT;
        o.y = '0;
        return o;
    endfunction

    rpy_link_t chain [NSTG+1];

    always_comb begin
        chain[0].valid       = s_valid;
        chain[0].r           = seed(s_data.roll_angle);
        chain[0].p           = seed(s_data.pitch_angle);
        chain[0].w           = seed(s_data.yaw_angle);
        chain[0].opcode      = s_data.opcode;
        chain[0].bone_length = s_data.bone_length;
    end

    // one cell per cordic iteration
    for (genvar i = 0; i < NSTG; i++) begin : g_cell
        rpy_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .shift    (5'(i)),
            .atan     (atan_val(i)),
            .link_in  (chain[i]),
            .link_out (chain[i+1])
        );
    end

    rpy_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .link_in   (chain[NSTG]),
        .valid_out (m_valid),
        .data_out  (m_data)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import rpy_pkg::*;

    localparam int LATENCY   = CORDIC_STAGES + 5;
    localparam int N_RANDOM  = 1600;
    localparam int CYCLE_CAP = 400000;

    // arctangent table of the rotator, 2^31 = pi
    localparam logic [31:0] ATAN_LUT [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rpy_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    rpy_out_t m_data;

    int errors;
    int cycles;
    bit src_done;

    rpy_to_homogeneous_transform u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // floor shift on a signed 64-bit value
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_q14(input longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // sine and cosine of a binary angle through the cordic rotator
    task automatic angle_sincos(input logic [15:0] ang, output longint sn, output longint cs);
        logic [31:0] ph;
        bit flip;
        longint x, y, z, nx, ny;
        ph = {ang, 16'h0};
        flip = ph[31] ^ ph[30];
        if (flip) ph = ph + 32'h80000000;
        z = longint'($signed(ph));
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z  = z - longint'(ATAN_LUT[i]);
            end else begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z  = z + longint'(ATAN_LUT[i]);
            end
            x = nx;
            y = ny;
        end
        cs = clamp_q14(floor_shift(x + 32768, 16));
        sn = clamp_q14(floor_shift(y + 32768, 16));
        if (flip) begin
            cs = -cs;
            sn = -sn;
        end
    endtask

    function automatic logic [15:0] mul2(input longint a, input longint b);
        return 16'(clamp_q14(floor_shift(a * b + 8192, 14)));
    endfunction

    function automatic logic [15:0] mul3(input longint a, input longint b, input longint c,
                                          input longint d, input longint e, input bit neg);
        longint t1, t2;
        t1 = a * b * c;
        t2 = d * e * 16384;
        return 16'(clamp_q14(floor_shift((neg ? t1 - t2 : t1 + t2) + (64'sd1 <<< 27), 28)));
    endfunction

    task automatic pose_to_matrix(input rpy_in_t w, output rpy_out_t r);
        longint sr, cr, sp, cp, sy, cy;
        angle_sincos(w.roll_angle, sr, cr);
        angle_sincos(w.pitch_angle, sp, cp);
        angle_sincos(w.yaw_angle, sy, cy);
        r.m00 = mul2(cy, cp);
        r.m01 = mul3(cy, sp, sr, sy, cr, 1);
        r.m02 = mul3(cy, sp, cr, sy, sr, 0);
        r.m10 = mul2(sy, cp);
        r.m11 = mul3(sy, sp, sr, cy, cr, 0);
        r.m12 = mul3(sy, sp, cr, cy, sr, 1);
        r.m20 = 16'(clamp_q14(-sp));
        r.m21 = mul2(cp, sr);
        r.m22 = mul2(cp, cr);
        r.trans_x = w.opcode ? w.bone_length : 16'h0;
    endtask

    // holds predicted matrices in order of acceptance
    class matrix_board;
        rpy_out_t pending[$];

        task note_pose(input rpy_in_t w);
            rpy_out_t r;
            pose_to_matrix(w, r);
            pending.push_back(r);
        endtask

        task check_matrix(input rpy_out_t got);
            rpy_out_t want;
            if (pending.size() == 0) begin
                $display("unexpected result word at %0t", $realtime);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.m00 != want.m00) report("m00", $signed(got.m00), $signed(want.m00));
            if (got.m01 != want.m01) report("m01", $signed(got.m01), $signed(want.m01));
            if (got.m02 != want.m02) report("m02", $signed(got.m02), $signed(want.m02));
            if (got.m10 != want.m10) report("m10", $signed(got.m10), $signed(want.m10));
            if (got.m11 != want.m11) report("m11", $signed(got.m11), $signed(want.m11));
            if (got.m12 != want.m12) report("m12", $signed(got.m12), $signed(want.m12));
            if (got.m20 != want.m20) report("m20", $signed(got.m20), $signed(want.m20));
            if (got.m21 != want.m21) report("m21", $signed(got.m21), $signed(want.m21));
            if (got.m22 != want.m22) report("m22", $signed(got.m22), $signed(want.m22));
            if (got.trans_x != want.trans_x) report("trans_x", got.trans_x, want.trans_x);
        endtask
    endclass

    matrix_board board = new();

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // bursts phase flag: no gaps at all while set
    bit no_gaps;

    // drive one word and hold it until accepted
    task automatic send_pose(input rpy_in_t w);
        int g;
        g = no_gaps ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        board.note_pose(w);
    endtask

    function automatic rpy_in_t make_pose(input bit op, input logic [15:0] r,
                                         input logic [15:0] p, input logic [15:0] y,
                                         input logic [15:0] len);
        rpy_in_t w;
        w.opcode = op;
        w.roll_angle = r;
        w.pitch_angle = p;
        w.yaw_angle = y;
        w.bone_length = len;
        return w;
    endfunction

    // pick an angle: special corners some of the time
    function automatic logic [15:0] pick_angle();
        logic [15:0] corners [8] = '{16'h0000, 16'h4000, 16'hC000, 16'h8000,
                                     16'h7FFF, 16'h3FFF, 16'h4001, 16'hBFFF};
        if ($urandom_range(0, 9) == 0) return corners[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    // stimulus
    initial begin
        static logic [15:0] edges [6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000,
                                          16'hC000, 16'h2000};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        no_gaps = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: angle extremes, right angles, both opcodes, length extremes
        for (int i = 0; i < 6; i++)
            send_pose(make_pose(i[0], edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6],
                                i[0] ? 16'hFFFF : 16'h0000));
        send_pose(make_pose(1'b1, 16'h4000, 16'h4000, 16'h4000, 16'h0001));
        send_pose(make_pose(1'b0, 16'hC000, 16'hC000, 16'hC000, 16'hFFFF));
        send_pose(make_pose(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_pose(make_pose(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_pose(make_pose(1'b1, 16'h3FFF, 16'h4001, 16'hBFFF, 16'h5555));
        send_pose(make_pose(1'b0, 16'h5555, 16'hAAAA, 16'h0001, 16'hAAAA));

        // let everything drain before the random part
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);

        for (int n = 0; n < N_RANDOM; n++) begin
            no_gaps = (n % 400) >= 300;
            send_pose(make_pose(1'($urandom_range(0, 1)), pick_angle(), pick_angle(),
                                pick_angle(), 16'($urandom)));
        end
        s_valid <= 1'b0;
        src_done = 1;
    end

    // receiver: random back-pressure
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            g = (cycles % 3000 > 2200) ? 0 : gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // result checker, sampled at the edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_matrix(m_data);
    end

    // end of run and timeout
    initial begin
        cycles = 0;
        while (!(src_done && board.pending.size() == 0) && cycles < CYCLE_CAP) begin
            @(posedge aclk);
            cycles++;
        end
        if (cycles >= CYCLE_CAP) begin
            $display("timeout");
            $display("testbench: errors");
            $finish;
        end else begin
            repeat (LATENCY + 10) @(posedge aclk);
            if (errors == 0 && board.pending.size() == 0) begin
                $display("testbench: clean");
            end else begin
                $display("testbench: errors");
            end
            $finish;
        end
    end

endmodule
